>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when ante holds, cons must hold in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared widths, codes and control/status types of the text console writer
// ---------------------------------------------------------------------------
package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // fixed field widths
  localparam int MODE_W  = 2;
  localparam int GLYPH_W = 8;
  localparam int ATTR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;

  // character and attribute codes
  localparam logic [GLYPH_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [GLYPH_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0]  RESET_ATTR   = 8'h07;

  // request modes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ,
    ST_RESULT
  } state_t;

  // kind of store sweep running this cycle
  typedef enum logic [1:0] {
    SW_NONE,
    SW_FILL,
    SW_COPY
  } sweep_t;

  // controller to datapath commands
  typedef struct packed {
    logic   item_ld;
    logic   cursor_step;
    logic   cursor_home;
    logic   read_item;
    logic   sweep_start;
    sweep_t sweep_kind;
    logic   fill_init;
    logic   result_ld;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    mode_t mode;
    logic  wraps_bottom;
    logic  fill_last;
    logic  copy_last;
    logic  out_free;
  } dp_status_t;

endpackage

>>> design/tcw_in_if.sv
// ---------------------------------------------------------------------------
// tcw_in_if
// Request channel: mode, glyph and cell index with valid/ready
// ---------------------------------------------------------------------------
interface tcw_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::MODE_W-1:0]   mode;
  logic [tcw_pkg::GLYPH_W-1:0]  glyph;
  logic [tcw_pkg::INDEX_W-1:0]  cell_index;

  modport source (output valid, mode, glyph, cell_index, input ready);
  modport sink   (input valid, mode, glyph, cell_index, output ready);
endinterface

>>> design/tcw_out_if.sv
// ---------------------------------------------------------------------------
// tcw_out_if
// Result channel: cursor position, scroll flag and read cell with valid/ready
// ---------------------------------------------------------------------------
interface tcw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::POS_W-1:0]   cursor_position;
  logic                        scrolled;
  logic [tcw_pkg::CELL_W-1:0]  read_cell;

  modport source (output valid, cursor_position, scrolled, read_cell, input ready);
  modport sink   (input valid, cursor_position, scrolled, read_cell, output ready);
endinterface

>>> design/tcw_datapath.sv
// ---------------------------------------------------------------------------
// tcw_datapath
// Cell store, cursor, attribute register, sweep counter and result register
// ---------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wr_data,
  input  logic [tcw_pkg::MODE_W-1:0]  in_mode,
  input  logic [tcw_pkg::GLYPH_W-1:0] in_glyph,
  input  logic [tcw_pkg::INDEX_W-1:0] in_cell_index,
  input  tcw_pkg::ctl_cmd_t           cmd,
  output tcw_pkg::dp_status_t         sts,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [tcw_pkg::POS_W-1:0]   out_cursor_position,
  output logic                        out_scrolled,
  output logic [tcw_pkg::CELL_W-1:0]  out_read_cell
);

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CNT_W     = $clog2(CELLS + 1);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int COPY_END  = CELLS - COLUMNS;
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  localparam int CELL_W = tcw_pkg::CELL_W;
  localparam int ATTR_W = tcw_pkg::ATTR_W;

  // configuration and latched request
  logic [ATTR_W-1:0]           attr_r;
  tcw_pkg::mode_t              mode_r;
  logic [tcw_pkg::GLYPH_W-1:0] glyph_r;
  logic [tcw_pkg::INDEX_W-1:0] idx_r;

  // cursor
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              scrolled_r, scrolled_nxt;

  // sweep and memory ports
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_prev;
  logic [CNT_W-1:0]  cnt_ahead;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data_r;
  logic [CELL_W-1:0] mem [CELLS];

  // result register
  logic              out_valid_r;
  logic [tcw_pkg::POS_W-1:0] out_pos_r;
  logic              out_scrolled_r;
  logic [CELL_W-1:0] out_cell_r;

  logic newline, last_row, last_col, wrap, is_put, put_glyph, idx_ok, out_free;

  // attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::RESET_ATTR;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      mode_r  <= tcw_pkg::mode_t'(in_mode);
      glyph_r <= in_glyph;
      idx_r   <= in_cell_index;
    end
  end

  // request decode
  always_comb begin
    newline   = (glyph_r == tcw_pkg::NEWLINE_CODE);
    last_row  = (row_r == ROW_W'(ROWS - 1));
    last_col  = (col_r == COL_W'(COLUMNS - 1));
    wrap      = newline || last_col;
    is_put    = (mode_r == tcw_pkg::MODE_PUT);
    put_glyph = cmd.cursor_step && is_put && !newline;
    idx_ok    = (32'(idx_r) < CELLS);
  end

  // cursor next value
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    pos_nxt      = pos_r;
    scrolled_nxt = scrolled_r;
    if (cmd.item_ld) begin
      scrolled_nxt = 1'b0;
    end
    if (cmd.cursor_home) begin
      row_nxt = '0;
      col_nxt = '0;
      pos_nxt = '0;
    end else if (cmd.cursor_step && is_put) begin
      scrolled_nxt = wrap && last_row;
      if (wrap) begin
        col_nxt = '0;
        if (last_row) begin
          pos_nxt = ADDR_W'(LAST_BASE);
        end else begin
          row_nxt = row_r + 1'b1;
          pos_nxt = pos_r - ADDR_W'(col_r) + ADDR_W'(COLUMNS);
        end
      end else begin
        col_nxt = col_r + 1'b1;
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      pos_r      <= '0;
      scrolled_r <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      pos_r      <= pos_nxt;
      scrolled_r <= scrolled_nxt;
    end
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.sweep_start) begin
      cnt_r <= '0;
    end else if (cmd.sweep_kind != tcw_pkg::SW_NONE) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign cnt_prev  = cnt_r - 1'b1;
  assign cnt_ahead = cnt_r + CNT_W'(COLUMNS);

  // write port: fill sweep, scroll copy one cell behind the read, or glyph
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = {attr_r, glyph_r};
    unique case (cmd.sweep_kind)
      tcw_pkg::SW_FILL: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[ADDR_W-1:0];
        wr_data = cmd.fill_init ? {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE}
                                : {attr_r, tcw_pkg::SPACE_CODE};
      end
      tcw_pkg::SW_COPY: begin
        wr_en   = (cnt_r != '0);
        wr_addr = cnt_prev[ADDR_W-1:0];
        wr_data = (cnt_r <= CNT_W'(COPY_END)) ? rd_data_r
                                              : {attr_r, tcw_pkg::SPACE_CODE};
      end
      default: begin
        wr_en = put_glyph;
      end
    endcase
  end

  // read port: one row ahead during scroll, else the requested cell
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ADDR_W'(idx_r);
    if (cmd.sweep_kind == tcw_pkg::SW_COPY) begin
      rd_en   = (cnt_r < CNT_W'(COPY_END));
      rd_addr = cnt_ahead[ADDR_W-1:0];
    end else if (cmd.read_item) begin
      rd_en = idx_ok;
    end
  end

  // cell store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_ld) begin
      out_pos_r      <= tcw_pkg::POS_W'(pos_nxt);
      out_scrolled_r <= scrolled_nxt;
      out_cell_r     <= (mode_r == tcw_pkg::MODE_READ && idx_ok) ? rd_data_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_position = out_pos_r;
  assign out_scrolled        = out_scrolled_r;
  assign out_read_cell       = out_cell_r;

  // status to controller
  always_comb begin
    sts.mode         = mode_r;
    sts.wraps_bottom = is_put && wrap && last_row;
    sts.fill_last    = (cnt_r == CNT_W'(CELLS - 1));
    sts.copy_last    = (cnt_r == CNT_W'(CELLS));
    sts.out_free     = out_free;
  end

endmodule

>>> design/tcw_ctrl.sv
// ---------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences reset fill, put, scroll, clear and read requests
// ---------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcw_pkg::dp_status_t sts,
  output tcw_pkg::ctl_cmd_t   cmd
);

  tcw_pkg::state_t state_r, state_nxt;
  tcw_pkg::state_t done_state;

  // where to go once a result is ready
  assign done_state = sts.out_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESULT;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        if (sts.fill_last) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        unique case (sts.mode)
          tcw_pkg::MODE_PUT: begin
            state_nxt = sts.wraps_bottom ? tcw_pkg::ST_SCROLL : done_state;
          end
          tcw_pkg::MODE_CLEAR: state_nxt = tcw_pkg::ST_CLEAR;
          tcw_pkg::MODE_READ:  state_nxt = tcw_pkg::ST_READ;
          default:             state_nxt = done_state;
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        if (sts.copy_last) state_nxt = done_state;
      end
      tcw_pkg::ST_CLEAR: begin
        if (sts.fill_last) state_nxt = done_state;
      end
      tcw_pkg::ST_READ:   state_nxt = done_state;
      tcw_pkg::ST_RESULT: begin
        if (sts.out_free) state_nxt = tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_INIT;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        cmd.sweep_kind = tcw_pkg::SW_FILL;
        cmd.fill_init  = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.item_ld = in_valid;
      end
      tcw_pkg::ST_EXEC: begin
        unique case (sts.mode)
          tcw_pkg::MODE_PUT: begin
            cmd.cursor_step = 1'b1;
            if (sts.wraps_bottom) begin
              cmd.sweep_start = 1'b1;
            end else begin
              cmd.result_ld = sts.out_free;
            end
          end
          tcw_pkg::MODE_CLEAR: begin
            cmd.cursor_home = 1'b1;
            cmd.sweep_start = 1'b1;
          end
          tcw_pkg::MODE_READ: cmd.read_item = 1'b1;
          default:            cmd.result_ld = sts.out_free;
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        cmd.sweep_kind = tcw_pkg::SW_COPY;
        cmd.result_ld  = sts.copy_last && sts.out_free;
      end
      tcw_pkg::ST_CLEAR: begin
        cmd.sweep_kind = tcw_pkg::SW_FILL;
        cmd.result_ld  = sts.fill_last && sts.out_free;
      end
      tcw_pkg::ST_READ:   cmd.result_ld = sts.out_free;
      tcw_pkg::ST_RESULT: cmd.result_ld = sts.out_free;
      default: begin
      end
    endcase
  end

endmodule

>>> design/text_console_writer_unit.sv
// ---------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: ROWS x COLUMNS cell store with cursor, scroll and clear
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request word (mode, glyph, cell_index); out_ch returns
//   one result word per request (cursor position, scrolled, read cell).
//   cfg_wr_en/cfg_wr_data load the attribute byte; write it only when idle.
// Timing:
//   one request at a time; ready is high only in the idle state.
//   put without scroll and unused mode: result loaded from the execute state
//   if the output register is free. read: goes through the read state
//   (registered memory read). scroll: one cell copied per cycle over the
//   single-port-write store. clear: a fill pass over all ROWS*COLUMNS cells.
// Reset:
//   rst_n homes the cursor and sets the attribute to 0x07, then a fill pass
//   writes blanks with attribute 0x07 into all ROWS*COLUMNS cells, one per
//   cycle (2000 at the default size); no request is accepted in that pass.
// Stall:
//   the result sits in an output register; the next request is still taken,
//   and its result waits in the controller until the register frees up.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wr_data,
  tcw_in_if.sink                     in_ch,
  tcw_out_if.source                  out_ch
);

  localparam logic [tcw_pkg::POS_W-1:0] LAST_POS = tcw_pkg::POS_W'((ROWS - 1) * COLUMNS);

  tcw_pkg::ctl_cmd_t   cmd;
  tcw_pkg::dp_status_t sts;

  // controller
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_mode             (in_ch.mode),
    .in_glyph            (in_ch.glyph),
    .in_cell_index       (in_ch.cell_index),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_cursor_position (out_ch.cursor_position),
    .out_scrolled        (out_ch.scrolled),
    .out_read_cell       (out_ch.read_cell)
  );

  // checks
  `ASSERT_ALWAYS(a_no_accept_in_sweep, !(in_ch.ready && cmd.sweep_kind != tcw_pkg::SW_NONE), "request accepted during store sweep")
  `ASSERT_ALWAYS(a_result_slot_free, !cmd.result_ld || sts.out_free, "result loaded over a pending word")
  `ASSERT_NEXT(a_one_item_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "second request taken back to back")
  `ASSERT_ALWAYS(a_scroll_on_last_row, !(out_ch.valid && out_ch.scrolled) || out_ch.cursor_position == LAST_POS, "scroll result off the last row")

endmodule

>>> bench/tb_text_console_writer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_console_writer_unit
// Self-checking bench for the text console writer. A behavioral copy of the
// cell store, cursor and attribute predicts every result word; a checker
// compares each word taken from the result channel with the oldest
// prediction. Directed words hit reset contents, glyph extremes, newline,
// clear, the unused mode and out-of-range reads; random phases then run
// wraps and scrolls under bursty input and a stalling result sink.
// ---------------------------------------------------------------------------
module tb_text_console_writer_unit;

  localparam int COLS         = tcw_pkg::COLUMNS_DEF;
  localparam int ROWS         = tcw_pkg::ROWS_DEF;
  localparam int CELLS        = COLS * ROWS;
  localparam int MAX_GAP      = 6;
  localparam int MAX_STALL    = 40;
  localparam int ITEM_BUDGET  = 1800;
  localparam int CYCLE_LIMIT  =
    4 * (ITEM_BUDGET * (CELLS + 4 + MAX_GAP + MAX_STALL) + CELLS + 100);
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_CAP   = 100;
  localparam int PHASE_WORDS  = 275;
  localparam int INDEX_MAX    = (1 << tcw_pkg::INDEX_W) - 1;
  localparam int INDEX_W      = tcw_pkg::INDEX_W;
  localparam int GLYPH_W      = tcw_pkg::GLYPH_W;
  localparam int ATTR_W       = tcw_pkg::ATTR_W;
  localparam int POS_W        = tcw_pkg::POS_W;
  localparam int CELL_W       = tcw_pkg::CELL_W;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic              scrolled;
    logic [CELL_W-1:0] read_cell;
  } console_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [ATTR_W-1:0] cfg_wr_data;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer_unit #(
    .COLUMNS (COLS),
    .ROWS    (ROWS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // shadow console state
  logic [CELL_W-1:0] screen_shadow [CELLS];
  int                cur_row;
  int                cur_col;
  logic [ATTR_W-1:0] attr_shadow;

  console_result_t pending_results [$];

  int          fail_count   = 0;
  int          report_count = 0;
  int unsigned cycle_count  = 0;
  int          burst_left;
  int          ready_run    = 0;
  bit          steady_flow;

  // reset contents: blanks in the power-on attribute, cursor home
  function automatic void console_reset();
    attr_shadow = tcw_pkg::RESET_ATTR;
    for (int i = 0; i < CELLS; i++)
      screen_shadow[i] = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
    cur_row = 0;
    cur_col = 0;
  endfunction

  // move to column 0 of the next row, scrolling past the last row
  function automatic bit advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++)
        screen_shadow[i] = {attr_shadow, tcw_pkg::SPACE_CODE};
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one request word to the shadow state and give its result word
  function automatic console_result_t console_step(input tcw_pkg::mode_t m,
                                                   input logic [GLYPH_W-1:0] g,
                                                   input logic [INDEX_W-1:0] ix);
    console_result_t res;
    res = '0;
    unique case (m)
      tcw_pkg::MODE_PUT: begin
        if (g == tcw_pkg::NEWLINE_CODE) begin
          res.scrolled = advance_row();
        end else begin
          screen_shadow[cur_row * COLS + cur_col] = {attr_shadow, g};
          cur_col++;
          if (cur_col >= COLS) res.scrolled = advance_row();
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_shadow[i] = {attr_shadow, tcw_pkg::SPACE_CODE};
        cur_row = 0;
        cur_col = 0;
      end
      tcw_pkg::MODE_READ: begin
        if (ix < CELLS) res.read_cell = screen_shadow[ix];
      end
      default: ;
    endcase
    res.cursor_position = POS_W'(cur_row * COLS + cur_col);
    return res;
  endfunction

  function automatic void report_field(input string field, input int want, input int got);
    fail_count++;
    if (report_count < REPORT_CAP) begin
      report_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  // send one request word, with random gaps between bursts
  task automatic send_word(input tcw_pkg::mode_t m, input logic [GLYPH_W-1:0] g,
                           input logic [INDEX_W-1:0] ix);
    int gap;
    if (!steady_flow && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.glyph      <= g;
    in_ch.cell_index <= ix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(console_step(m, g, ix));
  endtask

  // hold off input until every result is back and the block takes words
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || !in_ch.ready) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    attr_shadow = value;
  endtask

  // power-on contents, both ends of the store and past its end
  task automatic test_reset_contents();
    wait_idle();
    send_word(tcw_pkg::MODE_READ, 8'h00, 11'd0);
    send_word(tcw_pkg::MODE_READ, 8'hFF, INDEX_W'(CELLS - 1));
    send_word(tcw_pkg::MODE_READ, 8'h00, INDEX_W'(CELLS));
    send_word(tcw_pkg::MODE_READ, 8'hFF, INDEX_W'(INDEX_MAX));
  endtask

  // glyph extremes, newline, attribute extremes, then read back
  task automatic test_put_extremes();
    write_attribute(8'hFF);
    send_word(tcw_pkg::MODE_PUT, 8'h00, 11'd0);
    send_word(tcw_pkg::MODE_PUT, 8'hFF, INDEX_W'(INDEX_MAX));
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
    write_attribute(8'h00);
    send_word(tcw_pkg::MODE_PUT, 8'h41, 11'd0);
    send_word(tcw_pkg::MODE_READ, 8'h00, 11'd0);
    send_word(tcw_pkg::MODE_READ, 8'h00, 11'd1);
    send_word(tcw_pkg::MODE_READ, 8'h00, INDEX_W'(COLS));
    send_word(tcw_pkg::MODE_READ, 8'h00, INDEX_W'(COLS + 1));
  endtask

  // clear homes the cursor and blanks in the current attribute
  task automatic test_clear_screen();
    write_attribute(8'h5A);
    send_word(tcw_pkg::MODE_CLEAR, 8'hFF, INDEX_W'(INDEX_MAX));
    send_word(tcw_pkg::MODE_READ, 8'h00, 11'd0);
    send_word(tcw_pkg::MODE_READ, 8'h00, INDEX_W'(CELLS - 1));
    send_word(tcw_pkg::MODE_PUT, 8'h43, 11'd0);
    send_word(tcw_pkg::MODE_READ, 8'h00, 11'd0);
  endtask

  // unused mode changes nothing, even with a newline glyph
  task automatic test_unused_mode();
    send_word(tcw_pkg::MODE_NONE, tcw_pkg::NEWLINE_CODE, 11'd0);
    send_word(tcw_pkg::MODE_NONE, 8'($urandom_range(0, 255)),
              INDEX_W'($urandom_range(0, INDEX_MAX)));
  endtask

  // random phases: sparse newlines for row wraps, dense ones for scrolls
  task automatic test_random_traffic();
    int                 nl_pct;
    int                 pick;
    int                 near;
    logic [GLYPH_W-1:0] g;
    logic [INDEX_W-1:0] ix;
    tcw_pkg::mode_t     m;
    for (int phase = 0; phase < 6; phase++) begin
      unique case (phase)
        1:       write_attribute(8'hFF);
        2:       write_attribute(8'h00);
        default: write_attribute(8'($urandom_range(0, 255)));
      endcase
      nl_pct      = (phase % 2 == 1) ? 25 : 3;
      steady_flow = (phase == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        g    = 8'($urandom_range(0, 255));
        ix   = INDEX_W'($urandom_range(0, INDEX_MAX));
        pick = $urandom_range(0, 149);
        if (pick == 0) begin
          m = tcw_pkg::MODE_CLEAR;
        end else if (pick < 4) begin
          m = tcw_pkg::MODE_NONE;
        end else if (pick < 28) begin
          m    = tcw_pkg::MODE_READ;
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            ix = INDEX_W'($urandom_range(0, CELLS - 1));
          end else if (pick < 8) begin
            near = cur_row * COLS + cur_col - $urandom_range(0, 3);
            ix   = INDEX_W'((near < 0) ? 0 : near);
          end else begin
            ix = INDEX_W'($urandom_range(CELLS, INDEX_MAX));
          end
        end else begin
          m = tcw_pkg::MODE_PUT;
          if ($urandom_range(0, 99) < nl_pct) g = tcw_pkg::NEWLINE_CODE;
        end
        send_word(m, g, ix);
      end
    end
    steady_flow = 1'b0;
  endtask

  // result sink stall pattern: ready runs, short stalls, rare long stalls
  always @(posedge clk) begin : result_stall
    int pick;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_run    <= 0;
    end else if (steady_flow) begin
      out_ch.ready <= 1'b1;
    end else if (ready_run == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        out_ch.ready <= 1'b1;
        ready_run    <= $urandom_range(1, 16);
      end else if (pick < 9) begin
        out_ch.ready <= 1'b0;
        ready_run    <= $urandom_range(1, 4);
      end else begin
        out_ch.ready <= 1'b0;
        ready_run    <= $urandom_range(8, MAX_STALL);
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : result_check
    console_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (report_count < REPORT_CAP) begin
          report_count++;
          $error("unexpected result word, cursor_position %0d", out_ch.cursor_position);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_ch.cursor_position !== want.cursor_position)
          report_field("cursor_position", want.cursor_position, out_ch.cursor_position);
        if (out_ch.scrolled !== want.scrolled)
          report_field("scrolled", want.scrolled, out_ch.scrolled);
        if (out_ch.read_cell !== want.read_cell)
          report_field("read_cell", want.read_cell, out_ch.read_cell);
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = tcw_pkg::MODE_PUT;
    in_ch.glyph      = '0;
    in_ch.cell_index = '0;
    steady_flow      = 1'b0;
    burst_left       = 0;
    console_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_put_extremes();
    test_clear_screen();
    test_unused_mode();
    test_random_traffic();

    // drain, then watch for stray result words
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
